FILE: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_SEARCH     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // what every cell does at the next edge
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: sv/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit values built as a chain of
// cells, with push and pop at both ends and a membership search.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser
// s_*      in   item_value[31:0]               cmd[2:0]
// m_*      out  popped_value, found, occupancy status[1:0]
//
// one request per cycle while the output is not held: every command finishes in the edge that accepts it,
// the cell chain shifting in place and all cells comparing in parallel.
// a finished result waits in the output register; a new request is taken
// in the same cycle the waiting result leaves.
// rst clears the valid bits of the cells, the entry count and the output valid.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bdq_pkg::WORD_W-1:0]      s_tdata,  // item_value[31:0]
  input  logic [bdq_pkg::CMD_W-1:0]       s_tuser,  // cmd[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,  // popped_value[31:0], found[32],
                                                    // occupancy[37:33], zero[39:38]
  output logic [bdq_pkg::STATUS_W-1:0]    m_tuser   // status[1:0]
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      s_accept;
  logic                      empty;
  logic                      full;
  bdq_pkg::cell_ctrl_t       ctrl;
  bdq_pkg::status_e          status_next;
  logic [bdq_pkg::WORD_W-1:0] popped_next;
  logic                      found_next;

  logic                      cell_valid [DEPTH];
  logic [bdq_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic                      cell_match [DEPTH];
  logic [bdq_pkg::WORD_W-1:0] cell_pick [DEPTH];
  logic                      any_match;
  logic [bdq_pkg::WORD_W-1:0] last_value;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       lv;
    logic [bdq_pkg::WORD_W-1:0] ld;
    logic                       rv;
    logic [bdq_pkg::WORD_W-1:0] rd;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = ctrl.value;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    bdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[i]),
      .data        (cell_data[i]),
      .match       (cell_match[i]),
      .pick        (cell_pick[i])
    );
  end

  // at most one cell flags itself as last (none when empty), so an or of the picks selects it
  always_comb begin
    any_match  = 1'b0;
    last_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_match  = any_match | cell_match[i];
      last_value = last_value | cell_pick[i];
    end
  end

  always_comb begin
    ctrl.op     = bdq_pkg::OP_HOLD;
    ctrl.value  = s_tdata;
    count_next  = count;
    status_next = bdq_pkg::ST_OK;
    popped_next = '0;
    found_next  = 1'b0;
    unique case (s_tuser)
      bdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_next = bdq_pkg::ST_FULL;
        end else begin
          ctrl.op    = bdq_pkg::OP_PUSH_BACK;
          count_next = count + CNT_W'(1);
        end
      end
      bdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status_next = bdq_pkg::ST_FULL;
        end else begin
          ctrl.op    = bdq_pkg::OP_PUSH_FRONT;
          count_next = count + CNT_W'(1);
        end
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_next = bdq_pkg::ST_EMPTY;
        end else begin
          ctrl.op     = bdq_pkg::OP_POP_BACK;
          popped_next = last_value;
          count_next  = count - CNT_W'(1);
        end
      end
      bdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_next = bdq_pkg::ST_EMPTY;
        end else begin
          ctrl.op     = bdq_pkg::OP_POP_FRONT;
          popped_next = cell_data[0];
          count_next  = count - CNT_W'(1);
        end
      end
      bdq_pkg::CMD_SEARCH: begin
        if (empty) begin
          status_next = bdq_pkg::ST_EMPTY;
        end else begin
          found_next = any_match;
        end
      end
      default: ;
    endcase
    if (!s_accept) begin
      ctrl.op    = bdq_pkg::OP_HOLD;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tuser <= status_next;
      m_tdata <= {2'b00, bdq_pkg::OCC_W'(count_next), found_next, popped_next};
    end
  end

  // chain fill agrees with the count at both ends
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !cell_valid[0])
    else $error("head cell valid disagrees with entry count");

  a_full_tail: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(DEPTH)) == cell_valid[DEPTH-1])
    else $error("tail cell valid disagrees with entry count");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    s_accept && (count == '0) &&
    ((s_tuser == bdq_pkg::CMD_POP_BACK) || (s_tuser == bdq_pkg::CMD_POP_FRONT))
    |=> m_tvalid && (m_tuser == bdq_pkg::ST_EMPTY) && (m_tdata[31:0] == '0))
    else $error("pop on empty deque did not report empty");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> $stable(count))
    else $error("entry count moved without a request");

endmodule

FILE: sv/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the deque chain: holds a value and a valid bit, shifts toward
// either neighbor, and compares its value against the search key.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  bdq_pkg::cell_ctrl_t          ctrl,
  input  logic                         left_valid,
  input  logic [bdq_pkg::WORD_W-1:0]   left_data,
  input  logic                         right_valid,
  input  logic [bdq_pkg::WORD_W-1:0]   right_data,
  output logic                         valid,
  output logic [bdq_pkg::WORD_W-1:0]   data,
  output logic                         match,
  output logic [bdq_pkg::WORD_W-1:0]   pick
);

  logic is_tail;
  logic is_last;

  // first free slot and last held slot
  assign is_tail = left_valid && !valid;
  assign is_last = valid && !right_valid;

  assign match = valid && (data == ctrl.value);
  assign pick  = is_last ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        bdq_pkg::OP_PUSH_BACK:  if (is_tail) valid <= 1'b1;
        bdq_pkg::OP_PUSH_FRONT: valid <= left_valid;
        bdq_pkg::OP_POP_BACK:   if (is_last) valid <= 1'b0;
        bdq_pkg::OP_POP_FRONT:  valid <= right_valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      bdq_pkg::OP_PUSH_BACK:  if (is_tail) data <= ctrl.value;
      bdq_pkg::OP_PUSH_FRONT: data <= left_data;
      bdq_pkg::OP_POP_FRONT:  data <= right_data;
      default: ;
    endcase
  end

endmodule
